// File: rtl/tsst_pkg.sv
// ----------------------------------------------------------------------------
// Token scanner package
// Shared status codes, token classes and default sizes for the token scanner.
// ----------------------------------------------------------------------------
package tsst_pkg;

	// Default sizes of the two symbol tables and of one word.
	localparam int TABLE_ENTRIES_DEF = 32;
	localparam int MAX_WORD_LEN_DEF  = 16;

	// Status codes reported with each result word.
	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_NAME_LONG = 4'd1,
		ST_LEAD_ZERO = 4'd2,
		ST_NUM_LONG  = 4'd3,
		ST_VAR_FULL  = 4'd4,
		ST_NUM_FULL  = 4'd5,
		ST_KW_LONG   = 4'd6,
		ST_KW_BAD    = 4'd7,
		ST_BAD_CHAR  = 4'd8,
		ST_END       = 4'd9
	} status_t;

	// Token classes in bits 7:5 of a token code.
	localparam logic [2:0] CLS_KEYWORD  = 3'd0;
	localparam logic [2:0] CLS_VARIABLE = 3'd1;
	localparam logic [2:0] CLS_NUMBER   = 3'd2;
	localparam logic [2:0] CLS_OPERATOR = 3'd3;
	localparam logic [2:0] CLS_DELIM    = 3'd4;

	// Padding codes for table slots beyond the end of a word.
	localparam logic [4:0] PAD_LETTER = 5'd0;
	localparam logic [3:0] PAD_DIGIT  = 4'd15;

	// Letter codes of the two keywords (A is 1).
	localparam logic [4:0] KW_IF   [2] = '{5'd9, 5'd6};
	localparam logic [4:0] KW_ELSE [4] = '{5'd5, 5'd12, 5'd19, 5'd5};

endpackage

// File: rtl/tsst_table.sv
// ----------------------------------------------------------------------------
// Symbol table memory
// One row per entry, written once when the entry is created and read one row
// per cycle with registered read data.
// ----------------------------------------------------------------------------
module tsst_table #(
	parameter int ROWS  = 32,
	parameter int ROW_W = 80,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [ROW_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [ROW_W-1:0] rd_data
);

	logic [ROW_W-1:0] mem_q [ROWS];
	logic [ROW_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/token_scanner_with_symbol_tables_top.sv
// ----------------------------------------------------------------------------
// Token scanner with symbol tables
// Scans one character per word and emits token codes, interning lower-case
// names and decimal numbers into two symbol tables.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  input   | in_valid, in_stall   | char_code
//  output  | out_valid, out_stall | token_valid, token_code, status, last
//
// Finishing a name or number searches its table one row at a time: each row
// is read, then compared.
// The table rows are held in one memory per table with a single read port.
// Reset clears the scanner state; table contents stay undefined until written.
// in_stall stays high from acceptance until every result word has been taken.
module token_scanner_with_symbol_tables_top
	import tsst_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int MAX_WORD_LEN  = MAX_WORD_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       token_valid,
	output logic [7:0] token_code,
	output logic [3:0] status,
	output logic       last
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);
	localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
	localparam int BI_W  = $clog2(MAX_WORD_LEN);
	localparam int NROW_W = MAX_WORD_LEN * 5;
	localparam int DROW_W = MAX_WORD_LEN * 4;

	typedef enum logic [2:0] {
		S_READY, S_DECIDE, S_START, S_RD, S_CMP, S_WAIT
	} state_t;

	typedef enum logic [2:0] {
		M_IDLE, M_NAME, M_NUMBER, M_KEYWORD, M_STOPPED
	} mode_t;

	typedef enum logic [1:0] {
		K_NONE, K_WORD, K_EMIT, K_HALT
	} kind_t;

	state_t      state_q, after_q;
	mode_t       mode_q;
	status_t     stop_q;
	logic [7:0]  char_q;
	logic [LEN_W-1:0] len_q;
	logic [IDX_W-1:0] var_cnt_q, num_cnt_q, idx_q;
	logic [4:0]  buf_q [MAX_WORD_LEN];
	logic        o_valid_q, o_tvalid_q, o_last_q;
	logic [7:0]  o_code_q;
	status_t     o_status_q;

	// Character classes of the held character.
	logic is_lower, is_upper, is_digit;
	assign is_lower = (char_q >= 8'h61) && (char_q <= 8'h7a);
	assign is_upper = (char_q >= 8'h41) && (char_q <= 8'h5a);
	assign is_digit = (char_q >= 8'h30) && (char_q <= 8'h39);

	// Action of a character that starts afresh between tokens.
	kind_t      sc_kind;
	mode_t      sc_mode;
	logic [4:0] sc_letter;
	logic [7:0] sc_token;
	status_t    sc_status;
	always_comb begin
		sc_kind   = K_NONE;
		sc_mode   = M_IDLE;
		sc_letter = 5'(char_q - 8'h60);
		sc_token  = 8'h00;
		sc_status = ST_BAD_CHAR;
		priority if (char_q == 8'h20 || char_q == 8'h09 || char_q == 8'h0a) begin
			sc_kind = K_NONE;
		end else if (is_lower) begin
			sc_kind = K_WORD;
			sc_mode = M_NAME;
		end else if (is_digit) begin
			sc_kind   = K_WORD;
			sc_mode   = M_NUMBER;
			sc_letter = 5'(char_q - 8'h30);
		end else if (is_upper) begin
			sc_kind   = K_WORD;
			sc_mode   = M_KEYWORD;
			sc_letter = 5'(char_q - 8'h40);
		end else begin
			sc_kind = K_EMIT;
			unique case (char_q)
				8'h2b: sc_token = {CLS_OPERATOR, 5'd0};
				8'h2d: sc_token = {CLS_OPERATOR, 5'd1};
				8'h2a: sc_token = {CLS_OPERATOR, 5'd2};
				8'h2f: sc_token = {CLS_OPERATOR, 5'd3};
				8'h3d: sc_token = {CLS_OPERATOR, 5'd4};
				8'h3c: sc_token = {CLS_OPERATOR, 5'd5};
				8'h28: sc_token = {CLS_OPERATOR, 5'd6};
				8'h29: sc_token = {CLS_OPERATOR, 5'd7};
				8'h7b: sc_token = {CLS_DELIM, 5'd0};
				8'h7d: sc_token = {CLS_DELIM, 5'd1};
				8'h3b: sc_token = {CLS_DELIM, 5'd2};
				8'h23: begin
					sc_kind   = K_HALT;
					sc_status = ST_END;
				end
				default: sc_kind = K_HALT;
			endcase
		end
	end

	// Padded table rows of the pending word and the keyword checks.
	logic [NROW_W-1:0] name_row;
	logic [DROW_W-1:0] num_row;
	logic kw_if, kw_else;
	always_comb begin
		kw_if   = (len_q == LEN_W'(2));
		kw_else = (len_q == LEN_W'(4));
		for (int i = 0; i < MAX_WORD_LEN; i++) begin
			name_row[i*5 +: 5] = (LEN_W'(i) < len_q) ? buf_q[i] : PAD_LETTER;
			num_row[i*4 +: 4]  = (LEN_W'(i) < len_q) ? buf_q[i][3:0] : PAD_DIGIT;
			if (i < 2 && buf_q[i] != KW_IF[i]) begin
				kw_if = 1'b0;
			end
			if (i < 4 && buf_q[i] != KW_ELSE[i]) begin
				kw_else = 1'b0;
			end
		end
	end

	// Table search control.
	logic             is_name, at_end, tbl_full, do_rd, do_wr;
	logic [IDX_W-1:0] cnt;
	logic [NROW_W-1:0] name_rd;
	logic [DROW_W-1:0] num_rd;
	logic             hit;
	assign is_name  = (mode_q == M_NAME);
	assign cnt      = is_name ? var_cnt_q : num_cnt_q;
	assign at_end   = (idx_q == cnt);
	assign tbl_full = (cnt == IDX_W'(TABLE_ENTRIES));
	assign do_rd    = (state_q == S_RD) && !at_end;
	assign do_wr    = (state_q == S_RD) && at_end && !tbl_full;
	assign hit      = is_name ? (name_rd == name_row) : (num_rd == num_row);

	tsst_table #(.ROWS(TABLE_ENTRIES), .ROW_W(NROW_W), .AW(AW)) u_var_table (
		.clk     (clk),
		.wr_en   (do_wr && is_name),
		.wr_addr (cnt[AW-1:0]),
		.wr_data (name_row),
		.rd_en   (do_rd && is_name),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (name_rd)
	);

	tsst_table #(.ROWS(TABLE_ENTRIES), .ROW_W(DROW_W), .AW(AW)) u_num_table (
		.clk     (clk),
		.wr_en   (do_wr && !is_name),
		.wr_addr (cnt[AW-1:0]),
		.wr_data (num_row),
		.rd_en   (do_rd && !is_name),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (num_rd)
	);

	// Word buffer: one slot written per appended character.
	logic             buf_we;
	logic [BI_W-1:0]  buf_wa;
	logic [4:0]       buf_wd;
	always_comb begin
		buf_we = 1'b0;
		buf_wa = len_q[BI_W-1:0];
		buf_wd = sc_letter;
		if (state_q == S_START && sc_kind == K_WORD) begin
			buf_we = 1'b1;
			buf_wa = '0;
		end else if (state_q == S_DECIDE && len_q < LEN_W'(MAX_WORD_LEN) &&
				((mode_q == M_NAME && is_lower) || (mode_q == M_KEYWORD && is_upper) ||
				(mode_q == M_NUMBER && is_digit &&
				!(len_q == LEN_W'(1) && buf_q[0] == 5'd0)))) begin
			buf_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_q[buf_wa] <= buf_wd;
		end
	end

	// Sequencer, scanner state and registered result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_READY;
			after_q    <= S_READY;
			mode_q     <= M_IDLE;
			stop_q     <= ST_OK;
			len_q      <= '0;
			var_cnt_q  <= '0;
			num_cnt_q  <= '0;
			idx_q      <= '0;
			o_valid_q  <= 1'b0;
			char_q     <= '0;
			o_tvalid_q <= 1'b0;
			o_code_q   <= '0;
			o_status_q <= ST_OK;
			o_last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_READY: begin
					if (in_valid) begin
						char_q  <= char_code;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					o_tvalid_q <= 1'b0;
					o_code_q   <= '0;
					o_last_q   <= 1'b1;
					after_q    <= S_READY;
					priority if (mode_q == M_STOPPED) begin
						o_status_q <= stop_q;
						o_valid_q  <= 1'b1;
						state_q    <= S_WAIT;
					end else if ((mode_q == M_NAME && is_lower) ||
							(mode_q == M_NUMBER && is_digit) ||
							(mode_q == M_KEYWORD && is_upper)) begin
						if (buf_we) begin
							len_q   <= len_q + LEN_W'(1);
							state_q <= S_READY;
						end else begin
							mode_q    <= M_STOPPED;
							o_valid_q <= 1'b1;
							state_q   <= S_WAIT;
							if (mode_q == M_NAME) begin
								stop_q     <= ST_NAME_LONG;
								o_status_q <= ST_NAME_LONG;
							end else if (mode_q == M_KEYWORD) begin
								stop_q     <= ST_KW_LONG;
								o_status_q <= ST_KW_LONG;
							end else if (len_q == LEN_W'(1) && buf_q[0] == 5'd0) begin
								stop_q     <= ST_LEAD_ZERO;
								o_status_q <= ST_LEAD_ZERO;
							end else begin
								stop_q     <= ST_NUM_LONG;
								o_status_q <= ST_NUM_LONG;
							end
						end
					end else if (mode_q == M_IDLE) begin
						state_q <= S_START;
					end else if (mode_q == M_KEYWORD) begin
						o_valid_q <= 1'b1;
						state_q   <= S_WAIT;
						if (kw_if || kw_else) begin
							o_tvalid_q <= 1'b1;
							o_code_q   <= {CLS_KEYWORD, 4'd0, kw_else};
							o_status_q <= ST_OK;
							o_last_q   <= (sc_kind == K_NONE || sc_kind == K_WORD);
							after_q    <= S_START;
							mode_q     <= M_IDLE;
							len_q      <= '0;
						end else begin
							mode_q     <= M_STOPPED;
							stop_q     <= ST_KW_BAD;
							o_status_q <= ST_KW_BAD;
						end
					end else begin
						idx_q   <= '0;
						state_q <= S_RD;
					end
				end
				S_START: begin
					o_tvalid_q <= 1'b0;
					o_code_q   <= '0;
					o_last_q   <= 1'b1;
					after_q    <= S_READY;
					unique case (sc_kind)
						K_NONE: state_q <= S_READY;
						K_WORD: begin
							mode_q  <= sc_mode;
							len_q   <= LEN_W'(1);
							state_q <= S_READY;
						end
						K_EMIT: begin
							o_tvalid_q <= 1'b1;
							o_code_q   <= sc_token;
							o_status_q <= ST_OK;
							o_valid_q  <= 1'b1;
							state_q    <= S_WAIT;
						end
						K_HALT: begin
							mode_q     <= M_STOPPED;
							stop_q     <= sc_status;
							o_status_q <= sc_status;
							o_valid_q  <= 1'b1;
							state_q    <= S_WAIT;
						end
						default: state_q <= S_READY;
					endcase
				end
				S_RD: begin
					if (!at_end) begin
						state_q <= S_CMP;
					end else begin
						o_valid_q <= 1'b1;
						state_q   <= S_WAIT;
						if (tbl_full) begin
							o_tvalid_q <= 1'b0;
							o_code_q   <= '0;
							o_last_q   <= 1'b1;
							after_q    <= S_READY;
							mode_q     <= M_STOPPED;
							stop_q     <= is_name ? ST_VAR_FULL : ST_NUM_FULL;
							o_status_q <= is_name ? ST_VAR_FULL : ST_NUM_FULL;
						end else begin
							o_tvalid_q <= 1'b1;
							o_code_q   <= {is_name ? CLS_VARIABLE : CLS_NUMBER, 5'(cnt)};
							o_status_q <= ST_OK;
							o_last_q   <= (sc_kind == K_NONE || sc_kind == K_WORD);
							after_q    <= S_START;
							mode_q     <= M_IDLE;
							len_q      <= '0;
							if (is_name) begin
								var_cnt_q <= var_cnt_q + IDX_W'(1);
							end else begin
								num_cnt_q <= num_cnt_q + IDX_W'(1);
							end
						end
					end
				end
				S_CMP: begin
					if (hit) begin
						o_tvalid_q <= 1'b1;
						o_code_q   <= {is_name ? CLS_VARIABLE : CLS_NUMBER, 5'(idx_q)};
						o_status_q <= ST_OK;
						o_last_q   <= (sc_kind == K_NONE || sc_kind == K_WORD);
						o_valid_q  <= 1'b1;
						after_q    <= S_START;
						mode_q     <= M_IDLE;
						len_q      <= '0;
						state_q    <= S_WAIT;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_RD;
					end
				end
				S_WAIT: begin
					if (!out_stall) begin
						o_valid_q <= 1'b0;
						state_q   <= after_q;
					end
				end
				default: state_q <= S_READY;
			endcase
		end
	end

	assign in_stall    = (state_q != S_READY);
	assign out_valid   = o_valid_q;
	assign token_valid = o_tvalid_q;
	assign token_code  = o_code_q;
	assign status      = o_status_q;
	assign last        = o_last_q;

	// A new character is only taken once every result word has gone.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("input taken while a result word is pending");

	// Table fill counts never pass the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		var_cnt_q <= IDX_W'(TABLE_ENTRIES) && num_cnt_q <= IDX_W'(TABLE_ENTRIES))
		else $error("symbol table count out of range");

	// Every compare follows a row read.
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> $past(state_q) == S_RD)
		else $error("compare without a row read");

	// The word length never exceeds the buffer.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_WORD_LEN))
		else $error("word length out of range");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token scanner testbench
// Feeds source characters into the scanner and checks every token word
// against a behavioural predictor held here. A directed program covers the
// extreme word lengths, both keywords, every operator and delimiter and words
// ended directly by another kind of word. Random well-formed programs follow,
// under several idling mixes. The run then ends on one randomly chosen stop
// condition and sends any characters at all into the stopped block.
// ----------------------------------------------------------------------------
module tb_top;
	import tsst_pkg::*;

	localparam int ROWS = TABLE_ENTRIES_DEF;
	localparam int WLEN = MAX_WORD_LEN_DEF;
	localparam int IDLE_LIMIT = 4000;

	typedef enum logic [2:0] {SCAN_IDLE, SCAN_NAME, SCAN_NUMBER, SCAN_KEYWORD, SCAN_STOPPED}
		scan_t;

	typedef struct {
		bit         tv;
		logic [7:0] code;
		status_t    st;
		bit         fin;
	} token_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] char_code;
	logic       out_valid;
	logic       out_stall;
	logic       token_valid;
	logic [7:0] token_code;
	logic [3:0] status;
	logic       last;

	// Predictor state of the scanner.
	scan_t      scan;
	logic [4:0] word_codes [WLEN];
	int         word_len;
	logic [4:0] name_rows  [ROWS][WLEN];
	logic [3:0] digit_rows [ROWS][WLEN];
	int         name_cnt;
	int         num_cnt;
	status_t    halt_status;

	token_t     tokens_due[$];
	string      known_names[$];
	string      known_numbers[$];

	int         send_pct;
	int         stall_pct;
	int         hold_cycles;
	int         chars_sent;
	int         tokens_seen;
	int         mismatches;
	int         idle_cnt;

	string      op_chars  = "+-*/=<()";
	string      dl_chars  = "{};";
	string      sep_chars = " \t\n+-*/=<(){};";

	token_scanner_with_symbol_tables_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .char_code(char_code),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_valid(token_valid), .token_code(token_code), .status(status), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predictor: predict_char is called once per accepted character.
	function automatic void put_token(bit tv, logic [7:0] code, status_t st);
		token_t t;
		t.tv = tv;
		t.code = code;
		t.st = st;
		t.fin = 1'b0;
		tokens_due.push_back(t);
	endfunction

	function automatic void halt_scan(status_t st);
		scan = SCAN_STOPPED;
		halt_status = st;
		put_token(1'b0, 8'd0, st);
	endfunction

	function automatic logic [4:0] slot(int i, logic [4:0] pad);
		return (i < word_len) ? word_codes[i] : pad;
	endfunction

	function automatic int find_row(bit numeric);
		int count;
		bit hit;
		count = numeric ? num_cnt : name_cnt;
		for (int e = 0; e < count; e++) begin
			hit = 1'b1;
			for (int i = 0; i < WLEN; i++) begin
				if (numeric) begin
					if (digit_rows[e][i] != slot(i, {1'b0, PAD_DIGIT}) >> 0 & 5'hF)
						hit = 1'b0;
				end else if (name_rows[e][i] != slot(i, PAD_LETTER)) begin
					hit = 1'b0;
				end
			end
			if (hit)
				return e;
		end
		return -1;
	endfunction

	function automatic bit finish_word();
		int idx;
		logic [4:0] v;
		if (scan == SCAN_NAME) begin
			idx = find_row(1'b0);
			if (idx < 0) begin
				if (name_cnt >= ROWS) begin
					halt_scan(ST_VAR_FULL);
					return 1'b0;
				end
				for (int i = 0; i < WLEN; i++)
					name_rows[name_cnt][i] = slot(i, PAD_LETTER);
				idx = name_cnt++;
			end
			put_token(1'b1, {CLS_VARIABLE, idx[4:0]}, ST_OK);
		end else if (scan == SCAN_NUMBER) begin
			idx = find_row(1'b1);
			if (idx < 0) begin
				if (num_cnt >= ROWS) begin
					halt_scan(ST_NUM_FULL);
					return 1'b0;
				end
				for (int i = 0; i < WLEN; i++) begin
					v = slot(i, {1'b0, PAD_DIGIT});
					digit_rows[num_cnt][i] = v[3:0];
				end
				idx = num_cnt++;
			end
			put_token(1'b1, {CLS_NUMBER, idx[4:0]}, ST_OK);
		end else if (scan == SCAN_KEYWORD) begin
			if (word_len == 2 && word_codes[0] == KW_IF[0] && word_codes[1] == KW_IF[1])
				put_token(1'b1, {CLS_KEYWORD, 5'd0}, ST_OK);
			else if (word_len == 4 && word_codes[0] == KW_ELSE[0]
					&& word_codes[1] == KW_ELSE[1] && word_codes[2] == KW_ELSE[2]
					&& word_codes[3] == KW_ELSE[3])
				put_token(1'b1, {CLS_KEYWORD, 5'd1}, ST_OK);
			else begin
				halt_scan(ST_KW_BAD);
				return 1'b0;
			end
		end
		scan = SCAN_IDLE;
		word_len = 0;
		return 1'b1;
	endfunction

	function automatic void open_word(scan_t m, logic [4:0] code);
		scan = m;
		word_codes[0] = code;
		word_len = 1;
	endfunction

	function automatic void start_char(logic [7:0] c);
		if (c == " " || c == "\t" || c == "\n")
			return;
		if (c >= "a" && c <= "z")
			open_word(SCAN_NAME, 5'(c - "a" + 1));
		else if (c >= "0" && c <= "9")
			open_word(SCAN_NUMBER, 5'(c - "0"));
		else if (c >= "A" && c <= "Z")
			open_word(SCAN_KEYWORD, 5'(c - "A" + 1));
		else if (c == "#")
			halt_scan(ST_END);
		else begin
			for (int i = 0; i < op_chars.len(); i++)
				if (c == op_chars[i]) begin
					put_token(1'b1, {CLS_OPERATOR, 5'(i)}, ST_OK);
					return;
				end
			for (int i = 0; i < dl_chars.len(); i++)
				if (c == dl_chars[i]) begin
					put_token(1'b1, {CLS_DELIM, 5'(i)}, ST_OK);
					return;
				end
			halt_scan(ST_BAD_CHAR);
		end
	endfunction

	function automatic void predict_char(logic [7:0] c);
		int n_prior;
		n_prior = tokens_due.size();
		if (scan == SCAN_STOPPED)
			put_token(1'b0, 8'd0, halt_status);
		else if (scan == SCAN_NAME && c >= "a" && c <= "z") begin
			if (word_len >= WLEN) halt_scan(ST_NAME_LONG);
			else word_codes[word_len++] = 5'(c - "a" + 1);
		end else if (scan == SCAN_NUMBER && c >= "0" && c <= "9") begin
			if (word_len == 1 && word_codes[0] == 5'd0) halt_scan(ST_LEAD_ZERO);
			else if (word_len >= WLEN) halt_scan(ST_NUM_LONG);
			else word_codes[word_len++] = 5'(c - "0");
		end else if (scan == SCAN_KEYWORD && c >= "A" && c <= "Z") begin
			if (word_len >= WLEN) halt_scan(ST_KW_LONG);
			else word_codes[word_len++] = 5'(c - "A" + 1);
		end else if (scan == SCAN_IDLE || finish_word())
			start_char(c);
		if (tokens_due.size() > n_prior)
			tokens_due[tokens_due.size() - 1].fin = 1'b1;
	endfunction

	// Sends one character word and predicts its tokens once it is taken.
	task automatic send_char(input logic [7:0] c);
		in_valid <= 1'b1;
		char_code <= c;
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
		end
		@(posedge clk);
		predict_char(c);
		chars_sent++;
		if ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// The block stalls its input straight after taking a character, so
	// dropping valid at the next edge never loses or repeats a word.
	task automatic wait_drained();
		@(posedge clk);
		in_valid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic string random_word(string first_set, string rest_set, int len);
		string s;
		s = "";
		s = {s, string'(first_set[$urandom_range(first_set.len() - 1)])};
		for (int i = 1; i < len; i++)
			s = {s, string'(rest_set[$urandom_range(rest_set.len() - 1)])};
		return s;
	endfunction

	function automatic int word_size();
		return ($urandom_range(99) < 10) ? WLEN : $urandom_range(1, 8);
	endfunction

	// One well-formed token, words always followed by a separator.
	task automatic send_token();
		int r;
		string s;
		r = $urandom_range(99);
		if (r < 30) begin
			if (name_cnt < ROWS && (known_names.size() == 0 || $urandom_range(1))) begin
				s = random_word("abcdefghijklmnopqrstuvwxyz",
					"abcdefghijklmnopqrstuvwxyz", word_size());
				known_names.push_back(s);
			end else
				s = known_names[$urandom_range(known_names.size() - 1)];
		end else if (r < 55) begin
			if (num_cnt < ROWS && (known_numbers.size() == 0 || $urandom_range(1))) begin
				s = ($urandom_range(19) == 0) ? "0"
					: random_word("123456789", "0123456789", word_size());
				known_numbers.push_back(s);
			end else
				s = known_numbers[$urandom_range(known_numbers.size() - 1)];
		end else if (r < 65)
			s = $urandom_range(1) ? "IF" : "ELSE";
		else begin
			send_char(sep_chars[$urandom_range(sep_chars.len() - 1)]);
			return;
		end
		send_text(s);
		send_char(sep_chars[$urandom_range(sep_chars.len() - 1)]);
	endtask

	function automatic bit legal_char(logic [7:0] c);
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
			return 1'b1;
		for (int i = 0; i < sep_chars.len(); i++)
			if (c == sep_chars[i])
				return 1'b1;
		return c == "#";
	endfunction

	task automatic test_directed();
		send_pct = 0;
		stall_pct = 0;
		send_text("IF ELSE+a\tzzzzzzzzzzzzzzzz 0;1234567890123456\n-*/=<(){}ab12IF;a 0 ");
		wait_drained();
	endtask

	task automatic test_random(input int sp, input int rp, input int count);
		int target;
		send_pct = sp;
		stall_pct = rp;
		target = chars_sent + count;
		while (chars_sent < target)
			send_token();
	endtask

	// The receiver holds off for a long stretch while characters keep coming.
	task automatic test_hold_off();
		send_pct = 0;
		stall_pct = 0;
		hold_cycles = 400;
		repeat (30) send_token();
		wait_drained();
	endtask

	// Ends the program with one stop condition, then feeds the stopped block.
	task automatic test_stop();
		logic [7:0] c;
		send_pct = 17;
		stall_pct = 17;
		send_char(" ");
		case ($urandom_range(7))
			0: send_text({random_word("q", "q", WLEN), "q"});
			1: send_text("05");
			2: send_text({random_word("123456789", "0123456789", WLEN), "7"});
			3: begin
				while (name_cnt < ROWS)
					send_text({random_word("abcdefghijklmnopqrstuvwxyz",
						"abcdefghijklmnopqrstuvwxyz", 12), " "});
				send_text("zyxwvutsrq ");
			end
			4: send_text("IFX ");
			5: send_text({random_word("ABCDEFGHIJKLMNOPQRSTUVWXYZ",
				"ABCDEFGHIJKLMNOPQRSTUVWXYZ", WLEN), "K"});
			6: begin
				do c = 8'($urandom_range(255)); while (legal_char(c));
				send_char(c);
			end
			default: send_text("ab#");
		endcase
		repeat (40) send_char(8'($urandom_range(255)));
		send_char(8'hFF);
		send_char(8'h00);
	endtask

	// Receiver stall: random, or a counted hold-off when one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Token check, sampled on the falling edge before the accepting edge.
	always @(negedge clk) begin
		token_t t;
		if (arst_n && out_valid && !out_stall) begin
			tokens_seen++;
			if (tokens_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token word: valid %0d code %h status %0d last %0d",
						token_valid, token_code, status, last);
			end else begin
				t = tokens_due.pop_front();
				if (token_valid !== t.tv || token_code !== t.code || status !== t.st
						|| last !== t.fin) begin
					mismatches++;
					if (mismatches <= 10)
						$display("token mismatch: expected %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
							t.tv, t.code, t.st, t.fin,
							token_valid, token_code, status, last);
				end
			end
		end
	end

	// Watchdog on cycles without any handshake.
	always @(negedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt > IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = 8'd0;
		hold_cycles = 0;
		send_pct = 0;
		stall_pct = 0;
		chars_sent = 0;
		tokens_seen = 0;
		mismatches = 0;
		idle_cnt = 0;
		scan = SCAN_IDLE;
		word_len = 0;
		name_cnt = 0;
		num_cnt = 0;
		halt_status = ST_OK;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(0, 0, 190);
		test_random(52, 0, 190);
		test_random(0, 52, 190);
		test_hold_off();
		test_random(17, 17, 190);
		test_stop();
		wait_drained();

		$display("Sent %0d characters and checked %0d token words.", chars_sent, tokens_seen);
		$display("Tables held %0d names and %0d numbers; final stop status %0d.",
			name_cnt, num_cnt, halt_status);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: token_scanner_with_symbol_tables_top.f
rtl/tsst_pkg.sv
rtl/tsst_table.sv
rtl/token_scanner_with_symbol_tables_top.sv
test/tb_top.sv
